/* hw/rtl/adc_code_density_histogram_defines.svh */
// Assertion macros shared by the histogram RTL.
`ifndef ADC_CODE_DENSITY_HISTOGRAM_DEFINES_SVH
`define ADC_CODE_DENSITY_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CHK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/adc_cdh_pkg.sv */
// Types and constants for the ADC code density histogram.
package adc_cdh_pkg;

   localparam int ROW_SEL_W = 7;    // row taken from the coarse code or the read row
   localparam int COL_SEL_W = 10;   // column taken from the fine code or the read column
   localparam int OUT_COUNT_W = 32; // width of the bin count in a response

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_COUNTED = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_READ    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/adc_cdh_dpath.sv */
// Histogram datapath: request registers, bin memory, saturating update, response register.
`include "adc_code_density_histogram_defines.svh"

module adc_cdh_dpath
   import adc_cdh_pkg::*;
#(
   parameter int ROW_COUNT    = 32,
   parameter int COLUMN_COUNT = 256,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_operation,
   input  logic signed [7:0] req_coarse_code,
   input  logic signed [9:0] req_fine_code,
   input  logic [4:0]        req_read_row,
   input  logic [7:0]        req_read_column,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_bin_count
);

   localparam int BIN_TOTAL = ROW_COUNT * COLUMN_COUNT;
   localparam int ADDR_W = $clog2(BIN_TOTAL);
   localparam logic [31:0] COARSE_LIMIT = 32'(2 * ROW_COUNT);
   localparam logic [31:0] ROW_LIMIT = 32'(ROW_COUNT);
   localparam logic [31:0] COLUMN_LIMIT = 32'(COLUMN_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_TOTAL - 1);

   logic [COUNT_WIDTH-1:0] mem [BIN_TOTAL];

   logic [ADDR_W-1:0]      clear_addr_ff, clear_addr_in;
   logic [ADDR_W-1:0]      addr_ff;
   logic                   op_ff;
   logic                   hit_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   out_valid_ff, out_valid_in;
   status_type             status_ff;
   logic [OUT_COUNT_W-1:0] count_ff;

   logic                   coarse_ok, fine_ok, read_ok, hit_in;
   logic [ROW_SEL_W-1:0]   row_sel;
   logic [COL_SEL_W-1:0]   col_sel;
   logic [ADDR_W-1:0]      addr_in;
   logic [COUNT_WIDTH-1:0] inc_value, result_value;
   logic [COUNT_WIDTH+OUT_COUNT_W-1:0] result_wide;
   status_type             status_in;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   // Decode the incoming request into a bin address and an in-range flag.
   always_comb begin
      coarse_ok = !req_coarse_code[7] && (32'(req_coarse_code[6:0]) < COARSE_LIMIT);
      fine_ok   = !req_fine_code[9] && (32'(req_fine_code[8:0]) < COLUMN_LIMIT);
      read_ok   = (32'(req_read_row) < ROW_LIMIT) && (32'(req_read_column) < COLUMN_LIMIT);
      if (req_operation == OP_READ) begin
         hit_in  = read_ok;
         row_sel = ROW_SEL_W'(req_read_row);
         col_sel = COL_SEL_W'(req_read_column);
      end else begin
         hit_in  = coarse_ok && fine_ok;
         row_sel = ROW_SEL_W'(req_coarse_code[7:1]);
         col_sel = COL_SEL_W'(req_fine_code);
      end
      addr_in = ADDR_W'(row_sel) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(col_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= addr_in;
         op_ff   <= req_operation;
         hit_ff  <= hit_in;
      end
   end

   // Saturating increment and result selection.
   always_comb begin
      inc_value = (rd_data_ff == {COUNT_WIDTH{1'b1}}) ? rd_data_ff : rd_data_ff + 1'b1;
      if (!hit_ff) begin
         result_value = '0;
         status_in    = (op_ff == OP_READ) ? STATUS_READ : STATUS_DROPPED;
      end else if (op_ff == OP_READ) begin
         result_value = rd_data_ff;
         status_in    = STATUS_READ;
      end else begin
         result_value = inc_value;
         status_in    = STATUS_COUNTED;
      end
      result_wide = {{OUT_COUNT_W{1'b0}}, result_value};
   end

   // Clearing sweep address.
   always_comb begin
      clear_addr_in = clear_addr_ff;
      if (cmd.clear_step && clear_addr_ff != LAST_ADDR) begin
         clear_addr_in = clear_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else begin
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Bin memory: one write port, one registered read port.
   always_comb begin
      mem_we    = cmd.clear_step || (cmd.apply && op_ff == OP_RECORD && hit_ff);
      mem_waddr = cmd.clear_step ? clear_addr_ff : addr_ff;
      mem_wdata = cmd.clear_step ? '0 : inc_value;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   // Response register.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.apply) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff <= status_in;
         count_ff  <= result_wide[OUT_COUNT_W-1:0];
      end
   end

   assign sts.clear_done = (clear_addr_ff == LAST_ADDR);
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_bin_count = count_ff;

   `CHK_NEXT(a_apply_loads_rsp, cmd.apply, out_valid_ff, "apply did not load the response")
   `CHK_IMPL(a_count_no_wrap, cmd.apply && op_ff == OP_RECORD && hit_ff, inc_value != '0,
             "bin counter wrapped to zero")
   `CHK_IMPL(a_clear_quiet, cmd.clear_step, !out_valid_ff && !cmd.apply,
             "response activity during clearing sweep")

endmodule

/* hw/rtl/adc_cdh_ctrl.sv */
// Histogram controller: clearing sweep and per-request sequencing.
`include "adc_code_density_histogram_defines.svh"

module adc_cdh_ctrl
   import adc_cdh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_APPLY;
         ST_APPLY: if (sts.out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_FETCH: cmd = '0;
         ST_APPLY: cmd.apply = sts.out_free;
         default:  cmd = '0;
      endcase
   end

   `CHK_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.clear_step, cmd.capture, cmd.apply}),
             "more than one datapath command at once")

endmodule

/* hw/rtl/adc_code_density_histogram.sv */
// Top level of the two-dimensional ADC code density histogram.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   req     | in        | req_valid, req_stall, req_operation, req_coarse_code,
//           |           | req_fine_code, req_read_row, req_read_column
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_bin_count
//
// A request passes through its steps in order: accept, memory read, then update and load of
// the response register; the registered bin memory read ahead of the update sets this.
// After reset the bin memory is swept to zero, one bin a cycle, through all
// ROW_COUNT * COLUMN_COUNT bins (8192 at the defaults); req_stall is high meanwhile.
// A stalled response holds the update step, so req_stall stays high until the
// response register frees; the next request may be accepted while a response waits.
module adc_code_density_histogram
   import adc_cdh_pkg::*;
#(
   parameter int ROW_COUNT    = 32,
   parameter int COLUMN_COUNT = 256,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic signed [7:0] req_coarse_code,
   input  logic signed [9:0] req_fine_code,
   input  logic [4:0]        req_read_row,
   input  logic [7:0]        req_read_column,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_bin_count
);

   // Commands down to the datapath, status back up to the controller.
   cmd_type cmd;
   sts_type sts;

   // Sequence the clearing sweep, then accept, fetch and apply one request at a time.
   adc_cdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the bins, decode requests, saturate counts and register the response.
   adc_cdh_dpath #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_coarse_code (req_coarse_code),
      .req_fine_code   (req_fine_code),
      .req_read_row    (req_read_row),
      .req_read_column (req_read_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_bin_count   (rsp_bin_count)
   );

endmodule
